@@ hdl/mcmp_pkg.sv @@
// Shared types and constants for the MIDI channel message parser.
`timescale 1ns / 1ps
`default_nettype none

package mcmp_pkg;

  // Event kinds, as reported on the result port
  typedef enum logic [1:0] {
    KIND_NOTE_OFF = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_CC       = 2'd2,
    KIND_BEND     = 2'd3
  } kind_e;

  // Parse phase of the message under way
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_D1   = 2'd1,
    PH_D2   = 2'd2
  } phase_e;

  // High nibbles of the decoded status bytes
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CC       = 4'hB;
  localparam logic [3:0] ST_BEND     = 4'hE;

  // First system real-time byte
  localparam logic [7:0] REALTIME_MIN = 8'hF8;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } event_t;

endpackage

`default_nettype wire

@@ hdl/mcmp_in_stage.sv @@
// Input register of the MIDI parser: holds one received byte.
`timescale 1ns / 1ps
`default_nettype none

module mcmp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       advance_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       take;

  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mcmp_decode.sv @@
// Status tracking and running-status state machine of the MIDI parser.
`timescale 1ns / 1ps
`default_nettype none

module mcmp_decode (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [7:0]       byte_i,
  output logic                  emit_o,
  output mcmp_pkg::event_t      event_o
);

  mcmp_pkg::phase_e phase_q, phase_d;
  mcmp_pkg::kind_e  cur_kind_q, cur_kind_d;
  mcmp_pkg::kind_e  run_kind_q, run_kind_d;
  logic [3:0]       cur_chan_q, cur_chan_d;
  logic [3:0]       run_chan_q, run_chan_d;
  logic             run_valid_q, run_valid_d;
  logic [6:0]       held_q, held_d;
  logic             is_realtime;
  logic             is_status;
  logic             decoded;
  mcmp_pkg::kind_e  st_kind;

  assign is_realtime = (byte_i >= mcmp_pkg::REALTIME_MIN);
  assign is_status   = byte_i[7];

  always_comb begin
    decoded = 1'b1;
    st_kind = mcmp_pkg::KIND_NOTE_OFF;
    unique case (byte_i[7:4])
      mcmp_pkg::ST_NOTE_OFF: st_kind = mcmp_pkg::KIND_NOTE_OFF;
      mcmp_pkg::ST_NOTE_ON:  st_kind = mcmp_pkg::KIND_NOTE_ON;
      mcmp_pkg::ST_CC:       st_kind = mcmp_pkg::KIND_CC;
      mcmp_pkg::ST_BEND:     st_kind = mcmp_pkg::KIND_BEND;
      default:               decoded = 1'b0;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    cur_kind_d  = cur_kind_q;
    cur_chan_d  = cur_chan_q;
    run_kind_d  = run_kind_q;
    run_chan_d  = run_chan_q;
    run_valid_d = run_valid_q;
    held_d      = held_q;
    emit_o      = 1'b0;

    event_o.kind        = cur_kind_q;
    event_o.channel     = cur_chan_q;
    event_o.first_data  = held_q;
    event_o.second_data = byte_i[6:0];
    if (cur_kind_q == mcmp_pkg::KIND_NOTE_ON && byte_i[6:0] == 7'd0) begin
      event_o.kind = mcmp_pkg::KIND_NOTE_OFF;
    end

    if (is_realtime) begin
      // real-time bytes pass through without touching state
    end else if (is_status) begin
      if (decoded) begin
        cur_kind_d  = st_kind;
        cur_chan_d  = byte_i[3:0];
        run_kind_d  = st_kind;
        run_chan_d  = byte_i[3:0];
        run_valid_d = 1'b1;
        phase_d     = mcmp_pkg::PH_D1;
      end else begin
        run_valid_d = 1'b0;
        phase_d     = mcmp_pkg::PH_IDLE;
      end
    end else begin
      unique case (phase_q)
        mcmp_pkg::PH_IDLE: begin
          // reuse running status, this byte is then the first data byte
          if (run_valid_q) begin
            cur_kind_d = run_kind_q;
            cur_chan_d = run_chan_q;
            held_d     = byte_i[6:0];
            phase_d    = mcmp_pkg::PH_D2;
          end
        end
        mcmp_pkg::PH_D1: begin
          held_d  = byte_i[6:0];
          phase_d = mcmp_pkg::PH_D2;
        end
        mcmp_pkg::PH_D2: begin
          emit_o  = 1'b1;
          phase_d = mcmp_pkg::PH_IDLE;
        end
        default: begin
          // unreachable phase: drop data bytes
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mcmp_pkg::PH_IDLE;
      cur_kind_q  <= mcmp_pkg::KIND_NOTE_OFF;
      cur_chan_q  <= 4'd0;
      run_kind_q  <= mcmp_pkg::KIND_NOTE_OFF;
      run_chan_q  <= 4'd0;
      run_valid_q <= 1'b0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      cur_kind_q  <= cur_kind_d;
      cur_chan_q  <= cur_chan_d;
      run_kind_q  <= run_kind_d;
      run_chan_q  <= run_chan_d;
      run_valid_q <= run_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      held_q <= held_d;
    end
  end

  a_emit_from_d2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> phase_q == mcmp_pkg::PH_D2)
    else $error("event emitted outside second data phase");

  a_realtime_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_realtime |=> $stable(phase_q) && $stable(run_valid_q))
    else $error("real-time byte changed parser state");

  a_undecoded_cancels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_status && !is_realtime && !decoded
    |=> !run_valid_q && phase_q == mcmp_pkg::PH_IDLE)
    else $error("undecoded status did not cancel running status");

endmodule

`default_nettype wire

@@ hdl/mcmp_out_stage.sv @@
// Result register of the MIDI parser: holds one event until taken.
`timescale 1ns / 1ps
`default_nettype none

module mcmp_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire mcmp_pkg::event_t event_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output mcmp_pkg::event_t      event_o
);

  logic             valid_q;
  mcmp_pkg::event_t event_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign event_o     = event_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      event_q <= event_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/midi_channel_message_parser.sv @@
// Top level of the MIDI channel message parser with running status.
`timescale 1ns / 1ps
`default_nettype none

// Feed one MIDI byte per input transaction; get one event transaction per
// completed note off, note on, control change or pitch bend message. Each
// byte is captured in an input register and, once the result register has room,
// consumed by the running-status state machine, whose event lands in a result
// register. The block sustains one byte per clock: a byte is consumed every
// cycle the result register is empty or being drained, so the only cause of
// input stall is a stalled result register holding an event while the input
// register is also full.
// Real-time bytes (0xF8 and up) are dropped without touching state; other
// undecoded status bytes abort the message under way and clear running
// status. A note on with velocity zero comes out as a note off.
module midi_channel_message_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      event_kind_o,
  output logic [3:0]      midi_channel_o,
  output logic [6:0]      first_data_o,
  output logic [6:0]      second_data_o
);

  logic             byte_valid;
  logic [7:0]       byte_held;
  logic             out_ready;
  logic             advance;
  logic             emit;
  mcmp_pkg::event_t dec_event;
  mcmp_pkg::event_t out_event;

  // Consume the held byte whenever a possible event has room to land
  assign advance = byte_valid && out_ready;

  mcmp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .valid_o    (byte_valid),
    .byte_o     (byte_held)
  );

  mcmp_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .byte_i  (byte_held),
    .emit_o  (emit),
    .event_o (dec_event)
  );

  mcmp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && emit),
    .event_i     (dec_event),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_o     (out_event)
  );

  // Unpack the held event onto the result ports
  assign event_kind_o   = out_event.kind;
  assign midi_channel_o = out_event.channel;
  assign first_data_o   = out_event.first_data;
  assign second_data_o  = out_event.second_data;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the MIDI channel message parser: random and directed byte streams.
`timescale 1ns / 1ps

module testbench;

  // Status nibbles that the parser does not decode; each one aborts a message (0xF only below 0xF8)
  localparam logic [3:0] ST_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] ST_PROGRAM       = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESSURE = 4'hD;
  localparam logic [3:0] ST_SYSTEM        = 4'hF;

  localparam int unsigned RANDOM_BYTES  = 1500;
  localparam int unsigned SEGMENT_BYTES = 150;
  localparam int unsigned MAX_GAP       = 18;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 12;

  // Tracks parser state alongside the block and holds the events it must emit.
  class channel_event_tracker;
    mcmp_pkg::phase_e phase;
    mcmp_pkg::kind_e  msg_kind;
    logic [3:0]       msg_channel;
    bit               running_on;
    mcmp_pkg::kind_e  running_kind;
    logic [3:0]       running_channel;
    logic [6:0]       held_first;
    mcmp_pkg::event_t awaited_events[$];
    int unsigned      failures;
    int unsigned      compared;
    int unsigned      kind_seen[4];

    function new();
      phase           = mcmp_pkg::PH_IDLE;
      msg_kind        = mcmp_pkg::KIND_NOTE_OFF;
      msg_channel     = '0;
      running_on      = 1'b0;
      running_kind    = mcmp_pkg::KIND_NOTE_OFF;
      running_channel = '0;
      held_first      = '0;
      failures        = 0;
      compared        = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function int unsigned pending();
      return awaited_events.size();
    endfunction

    // Advance the tracked state by one accepted byte; queue an event when one completes.
    function void take_byte(logic [7:0] b);
      mcmp_pkg::kind_e  k;
      bit               decoded;
      mcmp_pkg::event_t ev;
      if (b >= mcmp_pkg::REALTIME_MIN) return;
      if (b[7]) begin
        decoded = 1'b1;
        k = mcmp_pkg::KIND_NOTE_OFF;
        case (b[7:4])
          mcmp_pkg::ST_NOTE_OFF: k = mcmp_pkg::KIND_NOTE_OFF;
          mcmp_pkg::ST_NOTE_ON:  k = mcmp_pkg::KIND_NOTE_ON;
          mcmp_pkg::ST_CC:       k = mcmp_pkg::KIND_CC;
          mcmp_pkg::ST_BEND:     k = mcmp_pkg::KIND_BEND;
          default:               decoded = 1'b0;
        endcase
        if (!decoded) begin
          phase      = mcmp_pkg::PH_IDLE;
          running_on = 1'b0;
          return;
        end
        msg_kind        = k;
        msg_channel     = b[3:0];
        phase           = mcmp_pkg::PH_D1;
        running_on      = 1'b1;
        running_kind    = k;
        running_channel = b[3:0];
        return;
      end
      if (phase == mcmp_pkg::PH_IDLE) begin
        if (!running_on) return;
        msg_kind    = running_kind;
        msg_channel = running_channel;
        phase       = mcmp_pkg::PH_D1;
      end
      if (phase == mcmp_pkg::PH_D1) begin
        held_first = b[6:0];
        phase      = mcmp_pkg::PH_D2;
        return;
      end
      if (phase != mcmp_pkg::PH_D2) return;
      ev.kind        = (msg_kind == mcmp_pkg::KIND_NOTE_ON && b[6:0] == 7'd0) ?
                       mcmp_pkg::KIND_NOTE_OFF : msg_kind;
      ev.channel     = msg_channel;
      ev.first_data  = held_first;
      ev.second_data = b[6:0];
      awaited_events.push_back(ev);
      phase = mcmp_pkg::PH_IDLE;
    endfunction

    function void compare_field(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= 100)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    // Check one event transaction against the oldest awaited event.
    function void match_event(logic [1:0] kind, logic [3:0] chan, logic [6:0] d1,
                              logic [6:0] d2);
      mcmp_pkg::event_t ev;
      if (awaited_events.size() == 0) begin
        failures++;
        if (failures <= 100)
          $display("%0t: unexpected event, expected none, got kind %0d ch %0d data %0d %0d",
                   $time, kind, chan, d1, d2);
        return;
      end
      ev = awaited_events.pop_front();
      compared++;
      kind_seen[ev.kind]++;
      compare_field("event_kind", 8'(ev.kind), 8'(kind));
      compare_field("midi_channel", 8'(ev.channel), 8'(chan));
      compare_field("first_data", 8'(ev.first_data), 8'(d1));
      compare_field("second_data", 8'(ev.second_data), 8'(d2));
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] event_kind_o;
  logic [3:0] midi_channel_o;
  logic [6:0] first_data_o;
  logic [6:0] second_data_o;

  channel_event_tracker tracker = new();

  bit          sender_quiet   = 1'b0;
  bit          receiver_quiet = 1'b0;
  int unsigned hold_cycles    = 0;
  int unsigned items_sent     = 0;
  int unsigned realtime_sent  = 0;
  int unsigned stalled_cycles = 0;

  midi_channel_message_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .midi_channel_o (midi_channel_o),
    .first_data_o   (first_data_o),
    .second_data_o  (second_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Check every event transaction and count cycles of input back-pressure.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.match_event(event_kind_o, midi_channel_o, first_data_o, second_data_o);
    if (rst_ni && in_valid_i && in_stall_o)
      stalled_cycles++;
  end

  // Offer one byte; valid stays up after the transaction so back-to-back bytes need
  // no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_byte(b);
    if (b >= mcmp_pkg::REALTIME_MIN) realtime_sent++;
    else items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every awaited event has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tracker.pending() != 0);
  endtask

  function automatic logic [3:0] voice_status_nibble();
    case ($urandom_range(0, 3))
      0:       return mcmp_pkg::ST_NOTE_OFF;
      1:       return mcmp_pkg::ST_NOTE_ON;
      2:       return mcmp_pkg::ST_CC;
      default: return mcmp_pkg::ST_BEND;
    endcase
  endfunction

  function automatic logic [7:0] aborting_status();
    logic [3:0] low;
    low = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0:       return {ST_POLY_PRESSURE, low};
      1:       return {ST_PROGRAM, low};
      2:       return {ST_CHAN_PRESSURE, low};
      default: return {ST_SYSTEM, 1'b0, low[2:0]};
    endcase
  endfunction

  // Bias data toward the extremes; zero also exercises velocity-zero note on.
  function automatic logic [7:0] random_data();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h7F;
      default: return {1'b0, 7'($urandom_range(0, 127))};
    endcase
  endfunction

  // Emit one random unit: mostly well-formed messages, some broken ones and noise,
  // with real-time bytes sprinkled between bytes.
  task automatic send_random_unit();
    logic [7:0]  seq[$];
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      seq = {{voice_status_nibble(), 4'($urandom_range(0, 15))}, random_data(), random_data()};
    else if (pick < 65)
      seq = {random_data(), random_data()};
    else if (pick < 75)
      seq = {{voice_status_nibble(), 4'($urandom_range(0, 15))}, random_data()};
    else if (pick < 85)
      seq = {random_data()};
    else if (pick < 92)
      seq = {aborting_status()};
    else
      seq = {8'($urandom_range(0, 255))};
    foreach (seq[i]) begin
      if ($urandom_range(0, 15) == 0)
        send_byte(8'($urandom_range(mcmp_pkg::REALTIME_MIN, 8'hFF)));
      send_byte(seq[i]);
    end
  endtask

  // Receiver: wait a random number of cycles per event, or a long hold when asked.
  initial begin : result_sink
    int unsigned wait_cycles;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      wait_cycles = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (wait_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o && hold_cycles == 0) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned first_random;
    int unsigned segment;
    int unsigned segment_end;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, each message type, running status, velocity-zero
    // note on, real-time inside a message, aborts and stray data.
    send_byte({mcmp_pkg::ST_NOTE_ON, 4'h0}); send_byte(8'h00); send_byte(8'h7F);
    send_byte(8'h40); send_byte(8'h00);
    send_byte({mcmp_pkg::ST_NOTE_OFF, 4'hF}); send_byte(8'h7F); send_byte(8'h00);
    send_byte({mcmp_pkg::ST_CC, 4'hA}); send_byte(8'h07);
    send_byte(mcmp_pkg::REALTIME_MIN); send_byte(8'h64);
    send_byte({mcmp_pkg::ST_BEND, 4'hF}); send_byte(8'h7F); send_byte(8'h7F);
    send_byte(8'h01); send_byte(8'hFF); send_byte(8'h00);
    send_byte({ST_POLY_PRESSURE, 4'h5}); send_byte(8'h12); send_byte(8'h34);
    send_byte({mcmp_pkg::ST_NOTE_ON, 4'h5}); send_byte(8'h3C);
    send_byte({ST_PROGRAM, 4'h0}); send_byte(8'h3C); send_byte(8'h3C);
    send_byte({mcmp_pkg::ST_NOTE_ON, 4'h2}); send_byte(8'h3C);
    send_byte({mcmp_pkg::ST_CC, 4'h1}); send_byte(8'h01); send_byte(8'h02);
    send_byte({ST_SYSTEM, 4'h7}); send_byte(8'h11); send_byte({ST_SYSTEM, 4'h0});
    wait_drained();

    first_random = items_sent;
    segment = 0;
    while (items_sent - first_random < RANDOM_BYTES) begin
      sender_quiet   = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      // Hold the result side off while bytes keep coming, to fill the block.
      if (segment == 3) begin
        sender_quiet = 1'b1;
        hold_cycles  = LONG_HOLD;
      end
      if (segment == 6) wait_drained();
      segment_end = items_sent + SEGMENT_BYTES;
      while (items_sent < segment_end) send_random_unit();
      segment++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("Sent %0d bytes plus %0d real-time; compared %0d events, %0d stalled input cycles.",
             items_sent, realtime_sent, tracker.compared, stalled_cycles);
    $display("Events by kind: note off %0d, note on %0d, control %0d, pitch bend %0d.",
             tracker.kind_seen[mcmp_pkg::KIND_NOTE_OFF],
             tracker.kind_seen[mcmp_pkg::KIND_NOTE_ON],
             tracker.kind_seen[mcmp_pkg::KIND_CC],
             tracker.kind_seen[mcmp_pkg::KIND_BEND]);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("[midi_channel_message_parser] OK");
    end else begin
      $display("[midi_channel_message_parser] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("%0t: timeout with %0d events still awaited", $time, tracker.pending());
    $display("[midi_channel_message_parser] ERROR");
    $finish;
  end

endmodule

@@ midi_channel_message_parser.f @@
hdl/mcmp_pkg.sv
hdl/mcmp_in_stage.sv
hdl/mcmp_decode.sv
hdl/mcmp_out_stage.sv
hdl/midi_channel_message_parser.sv
bench/testbench.sv
